>>> sv/ksoa_pkg.sv
package ksoa_pkg;

  // Keymap size and default pulse counter width.
  localparam int KEY_COUNT       = 13;
  localparam int TABLE_SIZE      = 16;
  localparam int PULSE_WIDTH_DEF = 16;

  localparam int KEY_W   = 4;
  localparam int WORD_W  = 32;
  localparam int PLEN_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Injectable bits of each word, and the fixed bits of word two.
  localparam logic [WORD_W-1:0] MASK0   = 32'h0000_2182;
  localparam logic [WORD_W-1:0] MASK1   = 32'h000F_FC05;
  localparam logic [WORD_W-1:0] SD_BIT  = 32'h0002_0000;
  localparam logic [WORD_W-1:0] USB_BIT = 32'h0008_0000;
  localparam int USB_BIT_POS = 19;

  localparam logic [CFG_DATA_W-1:0] FIRST_REPEAT_DEF = 16'd500;
  localparam logic [CFG_DATA_W-1:0] REPEAT_DEF       = 16'd175;

  // Word select per keymap entry: 1 picks word one.
  localparam logic [TABLE_SIZE-1:0] KEY_GROUP = 16'h1FE0;

  localparam logic [WORD_W-1:0] KEY_BITS [TABLE_SIZE] = '{
    32'h0000_2002, 32'h0000_0002, 32'h0000_2000, 32'h0000_0080,
    32'h0000_0100, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
    32'h0000_0004, 32'h0000_0001, 32'h0004_0000, 32'h0002_0000,
    32'h0008_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  typedef enum logic [1:0] {
    REQ_SCAN        = 2'd0,
    REQ_PRESS       = 2'd1,
    REQ_RELEASE     = 2'd2,
    REQ_RELEASE_ALL = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_EN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 2'd2;

  // Result of the keymap search over one scan.
  typedef struct packed {
    logic             click_valid;
    logic [KEY_W-1:0] click_key;
    logic             last_held;
  } match_t;

  function automatic logic key_exists(input logic [KEY_W-1:0] k);
    return (32'(k) < KEY_COUNT) && (KEY_BITS[k] != '0);
  endfunction

endpackage

>>> sv/ksoa_keymatch.sv
// Keymap search: lowest entry that went from released to pressed, and
// whether the remembered key is still fully held.
module ksoa_keymatch (
  input  logic [ksoa_pkg::WORD_W-1:0] old_w0,
  input  logic [ksoa_pkg::WORD_W-1:0] old_w1,
  input  logic [ksoa_pkg::WORD_W-1:0] new_w0,
  input  logic [ksoa_pkg::WORD_W-1:0] new_w1,
  input  logic [ksoa_pkg::KEY_W-1:0]  last_key,
  output ksoa_pkg::match_t            match
);

  logic [ksoa_pkg::TABLE_SIZE-1:0] clicked;
  logic [ksoa_pkg::WORD_W-1:0]     last_word;

  always_comb begin
    for (int i = 0; i < ksoa_pkg::TABLE_SIZE; i++) begin
      clicked[i] = ksoa_pkg::key_exists(ksoa_pkg::KEY_W'(i)) &&
        (((ksoa_pkg::KEY_GROUP[i] ? old_w1 : old_w0) & ksoa_pkg::KEY_BITS[i]) != '0) &&
        (((ksoa_pkg::KEY_GROUP[i] ? new_w1 : new_w0) & ksoa_pkg::KEY_BITS[i]) == '0);
    end
  end

  // Priority encode, lowest index wins.
  always_comb begin
    match.click_valid = |clicked;
    match.click_key   = '0;
    for (int i = ksoa_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
      if (clicked[i]) begin
        match.click_key = ksoa_pkg::KEY_W'(i);
      end
    end
    last_word = ksoa_pkg::KEY_GROUP[last_key] ? new_w1 : new_w0;
    match.last_held = ksoa_pkg::key_exists(last_key) &&
                      ((last_word & ksoa_pkg::KEY_BITS[last_key]) == '0);
  end

endmodule

>>> sv/keypad_scan_override_autorepeat_core.sv
// A scan beat accepted at one edge shows its result beat on the master
// side from the next cycle onwards. Throughput: one beat per cycle unless a
// result beat is stalled; the single output register is refilled in the
// cycle it is taken, so the keymap search alone sets the cycle time.
// Events (press, release, release all) produce no result beat.
// Reset (synchronous, rst high) empties the output and restores all state.
module keypad_scan_override_autorepeat_core #(
  parameter int PULSE_WIDTH = ksoa_pkg::PULSE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input beats.
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, from bit 0: raw_status0[32], raw_status1[32], raw_status2[32],
  // override_active[1], now_ms[32], key_index[4], zero fill[3].
  input  logic [135:0] s_tdata,
  // s_tuser: req_type[2].
  input  logic [1:0]   s_tuser,
  // Result beats.
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, from bit 0: out_status0[32], out_status1[32], out_status2[32],
  // clicked_valid[1], clicked_key[4], repeat_valid[1], repeat_key[4],
  // remote_level[1], pulse_valid[1], pulse_length[16], zero fill[4].
  output logic [127:0] m_tdata,
  // Configuration writes; always ready.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ksoa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ksoa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int W = ksoa_pkg::WORD_W;
  localparam int K = ksoa_pkg::KEY_W;

  // Unpacked input fields.
  logic [W-1:0] raw0, raw1, raw2, now_ms;
  logic         ovr;
  logic [K-1:0] kidx;
  ksoa_pkg::req_t req;

  assign raw0   = s_tdata[31:0];
  assign raw1   = s_tdata[63:32];
  assign raw2   = s_tdata[95:64];
  assign ovr    = s_tdata[96];
  assign now_ms = s_tdata[128:97];
  assign kidx   = s_tdata[132:129];
  assign req    = ksoa_pkg::req_t'(s_tuser);

  // Configuration registers.
  logic                           remote_en;
  logic [ksoa_pkg::CFG_DATA_W-1:0] first_repeat_ms;
  logic [ksoa_pkg::CFG_DATA_W-1:0] repeat_ms;

  // Scanner state. The previous words of the model are simply the current
  // words before a scan, so only the current pair is stored.
  logic [W-1:0]           cur_word0, cur_word1, cur_word0_next, cur_word1_next;
  logic [W-1:0]           inject0, inject1, inject0_next, inject1_next;
  logic                   last_key_valid, last_key_valid_next;
  logic [K-1:0]           last_key, last_key_next;
  logic                   repeated_once, repeated_once_next;
  logic [W-1:0]           last_emit_time, last_emit_time_next;
  logic [PULSE_WIDTH-1:0] pulse_count, pulse_count_next;

  logic         accept;
  logic         scan;
  logic [127:0] result;

  ksoa_pkg::match_t match;

  // The output register can take a new beat when empty or being drained.
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign scan      = (req == ksoa_pkg::REQ_SCAN);
  assign cfg_ready = 1'b1;

  ksoa_keymatch u_match (
    .old_w0   (cur_word0),
    .old_w1   (cur_word1),
    .new_w0   (raw0),
    .new_w1   (raw1),
    .last_key (last_key),
    .match    (match)
  );

  always_comb begin
    logic [W-1:0] o0, o1, o2, elapsed, limit, bits;
    logic         rv, pv, level;
    logic [K-1:0] rk;
    logic [31:0]  cnt32;
    logic [ksoa_pkg::PLEN_W-1:0] plen;

    cur_word0_next      = cur_word0;
    cur_word1_next      = cur_word1;
    inject0_next        = inject0;
    inject1_next        = inject1;
    last_key_valid_next = last_key_valid;
    last_key_next       = last_key;
    repeated_once_next  = repeated_once;
    last_emit_time_next = last_emit_time;
    pulse_count_next    = pulse_count;

    bits = ksoa_pkg::KEY_BITS[kidx];

    case (req)
      ksoa_pkg::REQ_PRESS: begin
        if (ksoa_pkg::key_exists(kidx)) begin
          if (ksoa_pkg::KEY_GROUP[kidx]) inject1_next = inject1 & ~bits;
          else                           inject0_next = inject0 & ~bits;
        end
      end
      ksoa_pkg::REQ_RELEASE: begin
        if (ksoa_pkg::key_exists(kidx)) begin
          if (ksoa_pkg::KEY_GROUP[kidx]) inject1_next = inject1 | bits;
          else                           inject0_next = inject0 | bits;
        end
      end
      ksoa_pkg::REQ_RELEASE_ALL: begin
        inject0_next = inject0 | ksoa_pkg::MASK0;
        inject1_next = inject1 | ksoa_pkg::MASK1;
      end
      default: begin
        cur_word0_next = raw0;
        cur_word1_next = raw1;
      end
    endcase

    // Injected keys replace the masked bits only; raw words drive detection.
    if (ovr) begin
      o0 = (raw0 | ksoa_pkg::MASK0) & (~ksoa_pkg::MASK0 | inject0);
      o1 = (raw1 | ksoa_pkg::MASK1) & (~ksoa_pkg::MASK1 | inject1);
    end else begin
      o0 = raw0;
      o1 = raw1;
    end

    // Autorepeat: the elapsed time wraps with the millisecond clock.
    elapsed = now_ms - last_emit_time;
    limit   = W'(repeated_once ? repeat_ms : first_repeat_ms);
    rv = 1'b0;
    rk = '0;
    if (match.click_valid) begin
      rv = 1'b1;
      rk = match.click_key;
      if (scan) begin
        last_key_valid_next = 1'b1;
        last_key_next       = match.click_key;
        repeated_once_next  = 1'b0;
        last_emit_time_next = now_ms;
      end
    end else if (last_key_valid && match.last_held) begin
      if (elapsed > limit) begin
        rv = 1'b1;
        rk = last_key;
        if (scan) begin
          repeated_once_next  = 1'b1;
          last_emit_time_next = now_ms;
        end
      end
    end else if (scan) begin
      last_key_valid_next = 1'b0;
    end

    // Remote pulse length in scans, held at the counter's top value.
    level = raw2[ksoa_pkg::USB_BIT_POS];
    pv    = 1'b0;
    cnt32 = 32'(pulse_count);
    plen  = '0;
    if (level) begin
      if (scan && (pulse_count != '1)) pulse_count_next = pulse_count + 1'b1;
    end else if (pulse_count != '0) begin
      pv   = 1'b1;
      plen = (cnt32 > 32'h0000_FFFF) ? '1 : cnt32[ksoa_pkg::PLEN_W-1:0];
      if (scan) pulse_count_next = '0;
    end

    o2 = raw2 & ~ksoa_pkg::SD_BIT & ~(remote_en ? ksoa_pkg::USB_BIT : '0);

    result = {4'b0, plen, pv, level, rk, rv, match.click_key, match.click_valid,
              o2, o1, o0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_en       <= 1'b0;
      first_repeat_ms <= ksoa_pkg::FIRST_REPEAT_DEF;
      repeat_ms       <= ksoa_pkg::REPEAT_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ksoa_pkg::REG_REMOTE_EN:    remote_en       <= cfg_data[0];
        ksoa_pkg::REG_FIRST_REPEAT: first_repeat_ms <= cfg_data;
        ksoa_pkg::REG_REPEAT:       repeat_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_word0      <= '0;
      cur_word1      <= '0;
      inject0        <= ksoa_pkg::MASK0;
      inject1        <= ksoa_pkg::MASK1;
      last_key_valid <= 1'b0;
      last_key       <= '0;
      repeated_once  <= 1'b0;
      last_emit_time <= '0;
      pulse_count    <= '0;
    end else if (accept) begin
      cur_word0      <= cur_word0_next;
      cur_word1      <= cur_word1_next;
      inject0        <= inject0_next;
      inject1        <= inject1_next;
      last_key_valid <= last_key_valid_next;
      last_key       <= last_key_next;
      repeated_once  <= repeated_once_next;
      last_emit_time <= last_emit_time_next;
      pulse_count    <= pulse_count_next;
    end
  end

  // Result register: loaded by scans, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= scan;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && scan) begin
      m_tdata <= result;
    end
  end

endmodule

>>> sv/ksoa_checker.sv
module ksoa_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // A stalled result beat must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // A click is always emitted as the repeat key of the same scan.
  a_click_emits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[96] |-> m_tdata[101] && (m_tdata[105:102] == m_tdata[100:97]))
    else $error("clicked key not emitted");

  // A pulse ends only on a low remote level and has a nonzero length.
  a_pulse_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[107] |-> !m_tdata[106] && (m_tdata[123:108] != '0))
    else $error("bad pulse end");

  // An event beat accepted into an empty output leaves no result behind.
  a_event_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != 2'd0) && !m_tvalid |=> !m_tvalid)
    else $error("event produced a result beat");

endmodule

bind keypad_scan_override_autorepeat_core ksoa_checker u_ksoa_checker (.*);
